// ----- src/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Byte position within the current 3-byte group (one-hot)
	typedef enum logic [2:0] {
		PH0 = 3'b001,
		PH1 = 3'b010,
		PH2 = 3'b100
	} phase_t;

	// One request's worth of output characters, as queued between front and back
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
	} job_t;

	// Six-bit code to ASCII, standard alphabet A-Z a-z 0-9 + /
	function automatic logic [7:0] enc(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26) begin
			enc = 8'h41 + v;
		end else if (six < 6'd52) begin
			enc = 8'h61 + v - 8'd26;
		end else if (six < 6'd62) begin
			enc = 8'h30 + v - 8'd52;
		end else if (six == 6'd62) begin
			enc = 8'h2B;
		end else begin
			enc = 8'h2F;
		end
	endfunction

endpackage

// ----- src/b64e_front.sv -----
// Front end: accepts raw bytes, tracks the group phase and leftover bits,
// and builds the character job for each byte. Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output job_t       job
);

	phase_t     phase_q, phase_nxt;
	logic [3:0] left_q, left_nxt;

	// Character generation for the current byte
	always_comb begin
		job.chars    = {4{PAD_CHAR}};
		job.last_idx = 2'd0;
		phase_nxt    = PH0;
		left_nxt     = 4'd0;
		case (phase_q)
			PH1: begin
				job.chars[0] = enc({left_q[1:0], data_byte[7:4]});
				if (final_byte) begin
					job.chars[1] = enc({data_byte[3:0], 2'b00});
					job.last_idx = 2'd2;
				end else begin
					phase_nxt = PH2;
					left_nxt  = data_byte[3:0];
				end
			end
			PH2: begin
				job.chars[0] = enc({left_q, data_byte[7:6]});
				job.chars[1] = enc(data_byte[5:0]);
				job.last_idx = 2'd1;
			end
			default: begin
				job.chars[0] = enc(data_byte[7:2]);
				if (final_byte) begin
					job.chars[1] = enc({data_byte[1:0], 4'b0000});
					job.last_idx = 2'd3;
				end else begin
					phase_nxt = PH1;
					left_nxt  = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	// Group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH0;
			left_q  <= 4'd0;
		end else if (take) begin
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
		end
	end

endmodule

// ----- src/b64e_queue.sv -----
// Short job queue between front and back, built from flip-flops.
// Depends on b64e_pkg for the job type.
module b64e_queue import b64e_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/b64e_back.sv -----
// Back end: walks the characters of the head job into the output register,
// one per cycle while that register is free. Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       end_of_run
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       end_of_run_q;
	logic       emit, is_last;

	// One character leaves the head job when the output register frees up
	assign emit    = head_valid && (!out_valid_q || out_ready);
	assign is_last = (idx_q == head_job.last_idx);
	assign pop     = emit && is_last;

	// Character index within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q   <= head_job.chars[idx_q];
			end_of_run_q <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign end_of_run = end_of_run_q;

endmodule

// ----- src/base64_stream_encoder.sv -----
// Top level of the base64 stream encoder: front end, job queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one raw byte per request in
//   data_byte, with final_byte set on the last byte of a message.
//   Output channel (out_valid/out_ready) carries one ASCII character per
//   request in out_char; end_of_run marks the last character that a byte
//   produced. A byte yields 1, 2, 3 or 4 characters, padded with '=' when
//   a message ends before its last group of three bytes is full.
//   The first character of a byte is offered after it passes through the
//   job queue and then the output register. The back end sends one
//   character per cycle while the receiver is ready, so the output port
//   sets the throughput.
//   The input accepts a byte every cycle while the job queue
//   (QUEUE_DEPTH entries) has room; a stalled receiver fills the queue
//   and then drops in_ready, with no data lost.
//   Reset clears the group phase, the queue and the output register;
//   encoding starts at the beginning of a group.
module base64_stream_encoder_core import b64e_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       end_of_run
);

	job_t front_job, head_job;
	logic full, take, pop, head_valid;

	assign in_ready = !full;
	assign take     = in_valid && !full;

	// Byte intake and character generation
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (front_job)
	);

	// Decoupling queue
	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.push_job   (front_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Character serializer
	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.end_of_run (end_of_run)
	);

endmodule

// ----- dv/base64_stream_encoder_core_tb.sv -----
// Self-checking testbench for base64_stream_encoder_core: a directed byte table, then random
// messages under bursty input and a stalling receiver, checked against an in-bench encoder.
// Depends on b64e_pkg and the base64_stream_encoder_core RTL.
module base64_stream_encoder_core_tb import b64e_pkg::*;;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 8;
	localparam int RAND_BYTES   = 150;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int RUN_LIMIT    = 300000 * 2 * HALF_PERIOD;

	// Standard alphabet, first symbol in the top byte
	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} b64_char_t;

	typedef struct {
		logic [7:0]  data;
		logic        fin;
		int          n_typed;
		logic [31:0] typed;
	} byte_row_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_THREE_OF_FOUR,
		RDY_SPARSE
	} stall_mode_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_char;
	logic       end_of_run;

	// Encoder state mirrored by the bench
	phase_t     grp_phase;
	logic [3:0] grp_left;
	logic [7:0] nxt_chars [4];

	b64_char_t  pending_chars [$];
	byte_row_t  byte_table [$];
	int         mismatch_cnt = 0;
	int         burst_left;
	bit         hold_out;

	base64_stream_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.end_of_run (end_of_run)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [7:0] b64_sym(input logic [5:0] six);
		return B64_ALPHABET[8 * (63 - int'(six)) +: 8];
	endfunction

	// Characters produced by one byte; updates the mirrored group state
	function automatic int encode_byte(input logic [7:0] b, input logic fin);
		int n;
		n = 0;
		case (grp_phase)
			PH1: begin
				nxt_chars[0] = b64_sym({grp_left[1:0], b[7:4]});
				if (fin) begin
					nxt_chars[1] = b64_sym({b[3:0], 2'b00});
					nxt_chars[2] = PAD_CHAR;
					n = 3;
					grp_phase = PH0;
					grp_left = 4'd0;
				end else begin
					n = 1;
					grp_phase = PH2;
					grp_left = b[3:0];
				end
			end
			PH2: begin
				nxt_chars[0] = b64_sym({grp_left, b[7:6]});
				nxt_chars[1] = b64_sym(b[5:0]);
				n = 2;
				grp_phase = PH0;
				grp_left = 4'd0;
			end
			default: begin
				nxt_chars[0] = b64_sym(b[7:2]);
				if (fin) begin
					nxt_chars[1] = b64_sym({b[1:0], 4'b0000});
					nxt_chars[2] = PAD_CHAR;
					nxt_chars[3] = PAD_CHAR;
					n = 4;
					grp_phase = PH0;
					grp_left = 4'd0;
				end else begin
					n = 1;
					grp_phase = PH1;
					grp_left = {2'b00, b[1:0]};
				end
			end
		endcase
		return n;
	endfunction

	task automatic add_row(input logic [7:0] d, input logic f, input int n, input logic [31:0] e);
		byte_row_t r;
		r.data = d;
		r.fin = f;
		r.n_typed = n;
		r.typed = e;
		byte_table.push_back(r);
	endtask

	// Hold one request until accepted, then queue its characters
	task automatic offer_byte(input logic [7:0] d, input logic f, input int n_typed,
		input logic [31:0] typed);
		int n;
		int cnt;
		b64_char_t c;
		in_valid <= 1'b1;
		data_byte <= d;
		final_byte <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n = encode_byte(d, f);
		cnt = (n_typed != 0) ? n_typed : n;
		for (int k = 0; k < cnt; k++) begin
			c.ch = (n_typed != 0) ? typed[8 * (cnt - 1 - k) +: 8] : nxt_chars[k];
			c.last = (k == cnt - 1);
			pending_chars.push_back(c);
		end
	endtask

	// Burst pacing: once the current burst is used up, a random gap in three cases of four
	task automatic pace();
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Receiver: ready pattern chosen at random from four modes, plus one long hold-off
	initial begin
		stall_mode_t mode;
		int cyc;
		bit held;
		out_ready = 1'b0;
		mode = RDY_ALWAYS;
		cyc = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out && !held) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				if (cyc % 40 == 0) mode = stall_mode_t'($urandom_range(0, 3));
				cyc++;
				case (mode)
					RDY_ALWAYS:        out_ready <= 1'b1;
					RDY_COIN:          out_ready <= 1'($urandom_range(0, 1));
					RDY_THREE_OF_FOUR: out_ready <= (cyc % 4 != 0);
					default:           out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Output checker
	always @(posedge clk) begin
		b64_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, got char %h last %b",
					$time, out_char, end_of_run);
				mismatch_cnt++;
			end else begin
				want = pending_chars.pop_front();
				if (out_char !== want.ch) begin
					$display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
					mismatch_cnt++;
				end
				if (end_of_run !== want.last) begin
					$display("%0t: end_of_run expected %b got %b", $time, want.last,
						end_of_run);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("base64_stream_encoder_core_tb: errors");
		$finish;
	end

	// Stimulus
	initial begin
		int sent;
		int msg_len;
		bit pressure_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		final_byte = 1'b0;
		hold_out = 1'b0;
		burst_left = 1;
		grp_phase = PH0;
		grp_left = 4'd0;
		sent = 0;
		pressure_done = 0;

		// Single-byte messages at the extremes: flush at start of group
		add_row(8'h00, 1'b1, 4, "AA==");
		add_row(8'hFF, 1'b1, 4, "/w==");
		// Final at group end needs no padding
		add_row(8'hFF, 1'b0, 1, "/");
		add_row(8'hFF, 1'b0, 1, "/");
		add_row(8'hFF, 1'b1, 2, "//");
		// Two-byte message: flush after the second byte
		add_row(8'h00, 1'b0, 1, "A");
		add_row(8'h00, 1'b1, 3, "AA=");
		// "Man" -> TWFu
		add_row(8'h4D, 1'b0, 1, "T");
		add_row(8'h61, 1'b0, 1, "W");
		add_row(8'h6E, 1'b1, 2, "Fu");
		// Mask boundaries through each phase, predictor-checked
		add_row(8'hF0, 1'b0, 0, 32'h0);
		add_row(8'h0F, 1'b0, 0, 32'h0);
		add_row(8'hC0, 1'b1, 0, 32'h0);
		add_row(8'h3F, 1'b0, 0, 32'h0);
		add_row(8'hA5, 1'b1, 0, 32'h0);
		add_row(8'h80, 1'b0, 0, 32'h0);
		add_row(8'h01, 1'b0, 0, 32'h0);
		add_row(8'h7F, 1'b0, 0, 32'h0);
		add_row(8'h55, 1'b1, 0, 32'h0);
		add_row(8'hFE, 1'b1, 0, 32'h0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (byte_table[i]) begin
			offer_byte(byte_table[i].data, byte_table[i].fin, byte_table[i].n_typed,
				byte_table[i].typed);
			pace();
		end

		// Random messages of 1 to 12 bytes
		while (sent < RAND_BYTES) begin
			msg_len = $urandom_range(1, 12);
			if (!pressure_done && sent >= 60) begin
				// Back-to-back bytes while the receiver holds off
				hold_out = 1'b1;
				for (int k = 0; k < 24; k++) begin
					offer_byte(pick_byte(), (k % 5 == 4) || (k == 23), 0, 32'h0);
					sent++;
				end
				pressure_done = 1;
			end
			for (int k = 0; k < msg_len; k++) begin
				offer_byte(pick_byte(), k == msg_len - 1, 0, 32'h0);
				sent++;
				pace();
			end
		end
		in_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
			$display("base64_stream_encoder_core_tb: clean");
		end else begin
			$display("base64_stream_encoder_core_tb: errors");
		end
		$finish;
	end

endmodule
